// ----- rtl/assert_macros.svh -----
// Assertion macros for the compensation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- rtl/ptc_pkg.sv -----
// Package: types and constants for pressure and temperature compensation
`default_nettype none
package ptc_pkg;
	localparam int RawW = 20;
	localparam int DivStages = 64;

	typedef enum logic [1:0] {
		REG_TEMP    = 2'd0,
		REG_PRESS_A = 2'd1,
		REG_PRESS_B = 2'd2,
		REG_PRESS_C = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} calib_t;

	// word handed from the front stages to the divider
	typedef struct packed {
		logic signed [31:0] tc;
		logic signed [31:0] tf;
		logic [63:0]        num;
		logic [63:0]        den;
		logic [15:0]        p7;
		logic [15:0]        p8;
		logic [15:0]        p9;
	} front_t;

	// word handed from the divider to the back stages
	typedef struct packed {
		logic signed [31:0] tc;
		logic signed [31:0] tf;
		logic [63:0]        quo;
		logic               valid;
		logic [15:0]        p7;
		logic [15:0]        p8;
		logic [15:0]        p9;
	} divout_t;
endpackage
`default_nettype wire

// ----- rtl/pressure_temperature_compensation.sv -----
// Top level: pressure and temperature compensation pipeline
// Usage:
//  s_axis carries one raw sample pair per word; m_axis returns one result word
//  per sample, in order. Calibration is written through cfg_we/cfg_idx/cfg_data
//  while the block is idle; indexes above 3 are ignored.
//  Pipeline: 8 front stages, 65 divider stages (the first registers the
//  operands, each of the others yields one quotient bit), 4 back stages.
//  Throughput: one word per cycle unless the receiver stalls; the long divider pipeline sets latency.
//  Reset clears all valid bits and calibration registers to zero.
//  When the receiver stalls the whole pipeline freezes; s_axis_tready follows
//  m_axis_tready or an empty output slot, so nothing is lost or repeated.
//  s_axis_tdata: [19:0] raw_temperature, [39:20] raw_pressure.
//  m_axis_tdata: [31:0] temperature_centi, [63:32] fine_temperature,
//   [95:64] pressure_q24_8; m_axis_tuser: pressure_valid.
`default_nettype none
`include "assert_macros.svh"
module pressure_temperature_compensation (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [39:0]  s_axis_tdata,  // raw_temperature, raw_pressure
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [95:0]       m_axis_tdata,  // temperature_centi, fine_temperature, pressure_q24_8
	output logic              m_axis_tuser,  // pressure_valid
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_idx,
	input  wire logic [63:0]  cfg_data
);
	import ptc_pkg::*;

	logic [47:0] temp_q;
	logic [63:0] pa_q, pb_q;
	logic [15:0] pc_q;
	calib_t      cal;
	logic        en;
	logic        fv, dv, bv;
	front_t      fw;
	divout_t     dw;
	logic [31:0] tc, tf, pr;
	logic        pv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0; pa_q <= '0; pb_q <= '0; pc_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TEMP:    temp_q <= cfg_data[47:0];
				REG_PRESS_A: pa_q   <= cfg_data;
				REG_PRESS_B: pb_q   <= cfg_data;
				REG_PRESS_C: pc_q   <= cfg_data[15:0];
				default:     ;
			endcase
		end
	end

	assign cal = '{t1: temp_q[15:0], t2: temp_q[31:16], t3: temp_q[47:32],
		p1: pa_q[15:0], p2: pa_q[31:16], p3: pa_q[47:32], p4: pa_q[63:48],
		p5: pb_q[15:0], p6: pb_q[31:16], p7: pb_q[47:32], p8: pb_q[63:48],
		p9: pc_q};

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	ptc_front u_front (.clk, .arst_n, .en, .in_valid(s_axis_tvalid),
		.raw_t(s_axis_tdata[19:0]), .raw_p(s_axis_tdata[39:20]), .cal,
		.out_valid(fv), .out_word(fw));
	ptc_div u_div (.clk, .arst_n, .en, .in_valid(fv), .in_word(fw),
		.out_valid(dv), .out_word(dw));
	ptc_back u_back (.clk, .arst_n, .en, .in_valid(dv), .in_word(dw),
		.out_valid(bv), .tc, .tf, .press(pr), .pvalid(pv));

	assign m_axis_tvalid = bv;
	assign m_axis_tdata  = {pr, tf, tc};
	assign m_axis_tuser  = pv;

	`ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`ASSERT_IMPL(a_zero, clk, arst_n, !m_axis_tvalid || m_axis_tuser || m_axis_tdata[95:64] == 32'd0)
	`ASSERT_IMPL(a_rdy, clk, arst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
endmodule
`default_nettype wire

// ----- rtl/ptc_front.sv -----
// Front stages: temperature formula and pressure numerator/divisor
`default_nettype none
module ptc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [19:0]         raw_t,
	input  wire logic [19:0]         raw_p,
	input  wire ptc_pkg::calib_t     cal,
	output logic                     out_valid,
	output ptc_pkg::front_t          out_word
);
	import ptc_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [31:0] a_s1, d_s1;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5;
	logic signed [31:0] ad_s2, dd_s2;
	logic signed [31:0] tv1_s3, dds_s3;
	logic signed [31:0] tf_s4, tf_s5, tc_s5;
	logic signed [33:0] v1_s4;
	logic signed [63:0] sq_s5, m6_s5, n1_s5;
	logic signed [63:0] a3_s6, b5_s6, c2_s6, num1_s6, m6_s6;
	logic signed [31:0] tf_s6, tc_s6;
	logic signed [63:0] v2_s7, w_s7, num1_s7;
	logic signed [31:0] tf_s7, tc_s7;
	logic signed [63:0] den_s8, num_s8;
	logic signed [31:0] tf_s8, tc_s8;
	logic               v_s6, v_s7, v_s8;

	logic signed [31:0] tmp5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	assign tmp5 = tf_s4 * 32'sd5 + 32'sd128;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= 32'({12'd0, raw_t} >> 3) - 32'({cal.t1, 1'b0});
			d_s1   <= 32'({12'd0, raw_t} >> 4) - 32'(cal.t1);
			rp_s1  <= raw_p;
			ad_s2  <= a_s1 * 32'(cal.t2);
			dd_s2  <= d_s1 * d_s1;
			rp_s2  <= rp_s1;
			tv1_s3 <= ad_s2 >>> 11;
			dds_s3 <= (dd_s2 >>> 12) * 32'(cal.t3);
			rp_s3  <= rp_s2;
			rp_s4  <= rp_s3;
			// stage 4 result taken from tv1_s3/dds_s3 directly
			tf_s4  <= tv1_s3 + (dds_s3 >>> 14);
			v1_s4  <= 34'(tv1_s3 + (dds_s3 >>> 14)) - 34'sd128000;
			// stage 5
			tf_s5  <= tf_s4;
			tc_s5  <= tmp5 >>> 8;
			sq_s5  <= 64'(v1_s4) * 64'(v1_s4);
			m6_s5  <= 64'(v1_s4) * 64'(cal.p5);
			n1_s5  <= 64'(v1_s4) * 64'(cal.p2);
			rp_s5  <= rp_s4;
			// stage 6
			a3_s6  <= sq_s5 * 64'(cal.p6);
			b5_s6  <= (sq_s5 * 64'(cal.p3)) >>> 8;
			c2_s6  <= n1_s5 <<< 12;
			m6_s6  <= m6_s5;
			num1_s6 <= (64'sd1048576 - 64'(rp_s5)) <<< 31;
			tf_s6  <= tf_s5; tc_s6 <= tc_s5;
			// stage 7
			v2_s7  <= a3_s6 + (m6_s6 <<< 17) + (64'(cal.p4) <<< 35);
			w_s7   <= ((64'sd1 <<< 47) + b5_s6 + c2_s6) * 64'(cal.p1);
			num1_s7 <= num1_s6;
			tf_s7  <= tf_s6; tc_s7 <= tc_s6;
			// stage 8
			den_s8 <= w_s7 >>> 33;
			num_s8 <= (num1_s7 - v2_s7) * 64'sd3125;
			tf_s8  <= tf_s7; tc_s8 <= tc_s7;
		end
	end

	assign out_valid         = v_s8;
	assign out_word.tc       = tc_s8;
	assign out_word.tf       = tf_s8;
	assign out_word.num      = num_s8;
	assign out_word.den      = den_s8;
	assign out_word.p7       = cal.p7;
	assign out_word.p8       = cal.p8;
	assign out_word.p9       = cal.p9;
endmodule
`default_nettype wire

// ----- rtl/ptc_div.sv -----
// Pipelined signed 64-bit divider, one quotient bit per stage
`default_nettype none
module ptc_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire ptc_pkg::front_t    in_word,
	output logic                    out_valid,
	output ptc_pkg::divout_t        out_word
);
	import ptc_pkg::*;

	logic [DivStages:0]        v_q;
	logic [63:0]               rem_q [DivStages+1];
	logic [63:0]               quo_q [DivStages+1];
	logic [63:0]               dvs_q [DivStages+1];
	logic [DivStages:0]        neg_q;
	logic [DivStages:0]        zero_q;
	front_t                    side_q [DivStages+1];

	logic nn, nd;
	assign nn = in_word.num[63];
	assign nd = in_word.den[63];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en) begin
			v_q[0] <= in_valid;
			v_q[DivStages:1] <= v_q[DivStages-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= 64'd0;
			quo_q[0]  <= nn ? 64'd0 - in_word.num : in_word.num;
			dvs_q[0]  <= nd ? 64'd0 - in_word.den : in_word.den;
			neg_q[0]  <= nn ^ nd;
			zero_q[0] <= (in_word.den == 64'd0);
			side_q[0] <= in_word;
		end
	end

	for (genvar g = 0; g < DivStages; g++) begin : g_st
		logic [64:0] trial;
		logic [64:0] shifted;
		assign shifted = {rem_q[g], quo_q[g][63]};
		assign trial = shifted - {1'b0, dvs_q[g]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!trial[64]) begin
					rem_q[g+1] <= trial[63:0];
					quo_q[g+1] <= {quo_q[g][62:0], 1'b1};
				end else begin
					rem_q[g+1] <= shifted[63:0];
					quo_q[g+1] <= {quo_q[g][62:0], 1'b0};
				end
				dvs_q[g+1]  <= dvs_q[g];
				neg_q[g+1]  <= neg_q[g];
				zero_q[g+1] <= zero_q[g];
				side_q[g+1] <= side_q[g];
			end
		end
	end

	assign out_valid      = v_q[DivStages];
	assign out_word.tc    = side_q[DivStages].tc;
	assign out_word.tf    = side_q[DivStages].tf;
	assign out_word.quo   = neg_q[DivStages] ? 64'd0 - quo_q[DivStages] : quo_q[DivStages];
	assign out_word.valid = !zero_q[DivStages];
	assign out_word.p7    = side_q[DivStages].p7;
	assign out_word.p8    = side_q[DivStages].p8;
	assign out_word.p9    = side_q[DivStages].p9;

	logic unused;
	assign unused = ^{rem_q[DivStages], dvs_q[DivStages], side_q[DivStages].num,
		side_q[DivStages].den};
endmodule
`default_nettype wire

// ----- rtl/ptc_back.sv -----
// Back stages: pressure correction after the division
`default_nettype none
module ptc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire ptc_pkg::divout_t   in_word,
	output logic                    out_valid,
	output logic [31:0]             tc,
	output logic [31:0]             tf,
	output logic [31:0]             press,
	output logic                    pvalid
);
	import ptc_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [63:0] p_s1, q_s1, pq_s1, v2_s1;
	logic signed [63:0] p_s2, v2_s2;
	logic [63:0]        ll_s2;
	logic [31:0]        hl_s2, lh_s2;
	logic signed [63:0] p_s3, v1_s3, v2_s3;
	logic [15:0]        p7_s1, p7_s2, p7_s3;
	logic [31:0]        tc_s1, tc_s2, tc_s3, tc_s4;
	logic [31:0]        tf_s1, tf_s2, tf_s3, tf_s4, pr_s4;
	logic               ok_s1, ok_s2, ok_s3, ok_s4;
	logic signed [63:0] q_c, sum_c, fin_c;

	assign q_c = signed'(in_word.quo) >>> 13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	assign sum_c = p_s3 + v1_s3 + v2_s3;
	assign fin_c = (sum_c >>> 8) + (64'(signed'(p7_s3)) <<< 4);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= in_word.quo;
			q_s1   <= q_c;
			pq_s1  <= q_c * 64'(signed'(in_word.p9));
			v2_s1  <= (64'(signed'(in_word.p8)) * signed'(in_word.quo)) >>> 19;
			p7_s1  <= in_word.p7;
			tc_s1  <= in_word.tc; tf_s1 <= in_word.tf; ok_s1 <= in_word.valid;
			// low 64 bits of pq * q from 32-bit partial products
			ll_s2  <= 64'(pq_s1[31:0]) * 64'(q_s1[31:0]);
			hl_s2  <= pq_s1[63:32] * q_s1[31:0];
			lh_s2  <= pq_s1[31:0] * q_s1[63:32];
			p_s2   <= p_s1;
			v2_s2  <= v2_s1;
			p7_s2  <= p7_s1;
			tc_s2  <= tc_s1; tf_s2 <= tf_s1; ok_s2 <= ok_s1;
			v1_s3  <= signed'(ll_s2 + {hl_s2 + lh_s2, 32'd0}) >>> 25;
			p_s3   <= p_s2;
			v2_s3  <= v2_s2;
			p7_s3  <= p7_s2;
			tc_s3  <= tc_s2; tf_s3 <= tf_s2; ok_s3 <= ok_s2;
			pr_s4  <= ok_s3 ? fin_c[31:0] : 32'd0;
			tc_s4  <= tc_s3; tf_s4 <= tf_s3; ok_s4 <= ok_s3;
		end
	end

	assign out_valid = v_s4;
	assign tc        = tc_s4;
	assign tf        = tf_s4;
	assign press     = pr_s4;
	assign pvalid    = ok_s4;
endmodule
`default_nettype wire
